/* rtl/core/homing_position_motor_control_unit_macros.svh */
// assertion macros for the homing position motor control unit
// no dependencies; included by the files that carry assertions
`ifndef HOMING_POSITION_MOTOR_CONTROL_UNIT_MACROS_SVH
`define HOMING_POSITION_MOTOR_CONTROL_UNIT_MACROS_SVH

// plain condition checked at every clock edge out of reset
`define HPMC_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// same-cycle implication checked at every clock edge out of reset
`define HPMC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/core/hpmc_pkg.sv */
// shared types and constants for the homing position motor control unit
// no dependencies
package hpmc_pkg;

    localparam int unsigned PWM_TOP_DEF = 100;

    localparam int unsigned POS_W = 16;
    localparam int unsigned DUTY_W = 7;
    localparam int unsigned DB_W = 15;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_DUTY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOMING_DUTY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_TARGET = 2'd3;

    localparam logic [DUTY_W-1:0] MOVE_DUTY_RST = 7'd30;
    localparam logic [DUTY_W-1:0] HOMING_DUTY_RST = 7'd30;
    localparam logic [DB_W-1:0] DEADBAND_RST = 15'd10;
    localparam logic [POS_W-1:0] HOME_TARGET_RST = 16'd426;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_SET_TARGET = 2'd1,
        OP_HOME = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        PH_NOT_HOMED = 2'd0,
        PH_HOMING = 2'd1,
        PH_HOMED = 2'd2
    } phase_t;

    typedef struct packed {
        op_t op;
        logic [POS_W-1:0] target_position;
        logic [POS_W-1:0] encoder_count;
        logic limit_negative;
    } item_t;

    typedef struct packed {
        logic [DUTY_W-1:0] move_duty;
        logic [DUTY_W-1:0] homing_duty;
        logic [DB_W-1:0] deadband;
        logic [POS_W-1:0] home_target;
    } cfg_t;

    // axis state apart from the pwm compare, whose width follows PWM_TOP
    typedef struct packed {
        phase_t phase;
        logic motion;
        logic [POS_W-1:0] target;
        logic dir;
        logic brake;
    } state_t;

endpackage

/* rtl/core/hpmc_step.sv */
// next-state logic for one word: homing, deadband compare and drive selection
// depends on hpmc_pkg
module hpmc_step #(
    parameter int unsigned PWM_TOP = hpmc_pkg::PWM_TOP_DEF,
    parameter int unsigned CW = 7
) (
    input  hpmc_pkg::item_t  item,
    input  hpmc_pkg::cfg_t   cfg,
    input  hpmc_pkg::state_t st,
    input  logic [CW-1:0]    cmp_cur,
    output hpmc_pkg::state_t st_next,
    output logic [CW-1:0]    cmp_next,
    output logic             clear
);

    localparam logic [CW-1:0] TOP_C = CW'(PWM_TOP);

    // inverted compare, saturating at zero
    function automatic logic [CW-1:0] drive_cmp(input logic [hpmc_pkg::DUTY_W-1:0] duty);
        logic [CW-1:0] d;
        d = CW'(duty);
        return (d >= TOP_C) ? '0 : TOP_C - d;
    endfunction

    logic signed [hpmc_pkg::POS_W:0] err;
    logic signed [hpmc_pkg::POS_W:0] db;
    logic signed [hpmc_pkg::POS_W:0] db_neg;

    assign err = $signed({st.target[hpmc_pkg::POS_W-1], st.target})
               - $signed({item.encoder_count[hpmc_pkg::POS_W-1], item.encoder_count});
    assign db = $signed({2'b00, cfg.deadband});
    assign db_neg = -db;

    always_comb begin
        st_next = st;
        cmp_next = cmp_cur;
        clear = 1'b0;
        unique case (item.op)
            hpmc_pkg::OP_SET_TARGET: begin
                st_next.target = item.target_position;
                st_next.brake = 1'b1;
                st_next.motion = 1'b1;
            end
            hpmc_pkg::OP_HOME: begin
                st_next.phase = hpmc_pkg::PH_HOMING;
            end
            hpmc_pkg::OP_TICK: begin
                unique case (st.phase)
                    hpmc_pkg::PH_HOMING: begin
                        st_next.brake = 1'b1;
                        st_next.dir = 1'b1;
                        cmp_next = drive_cmp(cfg.homing_duty);
                        if (item.limit_negative) begin
                            clear = 1'b1;
                            st_next.target = cfg.home_target;
                            st_next.motion = 1'b1;
                            st_next.phase = hpmc_pkg::PH_HOMED;
                        end
                    end
                    hpmc_pkg::PH_HOMED: begin
                        st_next.brake = 1'b1;
                        if (!st.motion) begin
                            cmp_next = TOP_C;
                        end else begin
                            priority if (err > db) begin
                                st_next.dir = 1'b0;
                                cmp_next = drive_cmp(cfg.move_duty);
                            end else if (err < db_neg) begin
                                st_next.dir = 1'b1;
                                cmp_next = drive_cmp(cfg.move_duty);
                            end else begin
                                cmp_next = TOP_C;
                                st_next.motion = 1'b0;
                            end
                        end
                    end
                    default: begin
                        // not homed: ticks leave everything alone
                    end
                endcase
            end
            default: begin
                // unused code: report state unchanged
            end
        endcase
    end

endmodule

/* rtl/core/homing_position_motor_control_unit.sv */
// path: a word accepted into the input register moves on into the result register,
// which drives the m_ ports; it waits there while the result register is full and unread
// throughput: one word per cycle; the input register keeps taking a word while a
// finished result waits, stalling only when both registers are full and m_ready is low
// reset: aresetn synchronous active low; config back to defaults, axis not homed,
// idle, brake applied, compare at PWM_TOP (stopped), both registers empty
module homing_position_motor_control_unit #(
    parameter int unsigned PWM_TOP = hpmc_pkg::PWM_TOP_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    // config write port
    input  logic                              cfg_we,
    input  logic [hpmc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hpmc_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    // input words
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_operation,
    input  logic signed [hpmc_pkg::POS_W-1:0] s_target_position,
    input  logic [hpmc_pkg::POS_W-1:0]        s_encoder_count,
    input  logic                              s_limit_negative,

    // result words
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_drive_negative,
    output logic [6:0]                        m_pwm_compare,
    output logic                              m_brake_release,
    output logic                              m_encoder_clear,
    output logic [1:0]                        m_home_status,
    output logic                              m_moving
);

`include "homing_position_motor_control_unit_macros.svh"

    // compare register holds any value up to PWM_TOP, reported as its low 7 bits
    localparam int unsigned CMP_W = $clog2(PWM_TOP + 1);
    localparam int unsigned CW = (CMP_W > 7) ? CMP_W : 7;
    localparam logic [CW-1:0] TOP_C = CW'(PWM_TOP);

    // config registers
    hpmc_pkg::cfg_t cfg_reg;

    // input register
    logic            in_vld_reg;
    hpmc_pkg::item_t in_item_reg;

    // axis state
    hpmc_pkg::state_t st_reg;
    hpmc_pkg::state_t st_next;
    logic [CW-1:0]    cmp_reg;
    logic [CW-1:0]    cmp_next;
    logic             clear_next;

    // result register
    logic             out_vld_reg;
    logic             out_dir_reg;
    logic [6:0]       out_cmp_reg;
    logic             out_brake_reg;
    logic             out_clear_reg;
    logic [1:0]       out_phase_reg;
    logic             out_motion_reg;

    logic advance;
    logic s_fire;

    // the input register moves on when the result register is empty or being read
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign s_fire = s_valid && s_ready;

    // config writes land unchecked; the user issues them only while the block is idle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.move_duty <= hpmc_pkg::MOVE_DUTY_RST;
            cfg_reg.homing_duty <= hpmc_pkg::HOMING_DUTY_RST;
            cfg_reg.deadband <= hpmc_pkg::DEADBAND_RST;
            cfg_reg.home_target <= hpmc_pkg::HOME_TARGET_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                hpmc_pkg::CFG_MOVE_DUTY: cfg_reg.move_duty <= cfg_wdata[hpmc_pkg::DUTY_W-1:0];
                hpmc_pkg::CFG_HOMING_DUTY: begin
                    cfg_reg.homing_duty <= cfg_wdata[hpmc_pkg::DUTY_W-1:0];
                end
                hpmc_pkg::CFG_DEADBAND: cfg_reg.deadband <= cfg_wdata[hpmc_pkg::DB_W-1:0];
                hpmc_pkg::CFG_HOME_TARGET: cfg_reg.home_target <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input register: valid is control, payload unreset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_fire) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.op <= hpmc_pkg::op_t'(s_operation);
            in_item_reg.target_position <= s_target_position;
            in_item_reg.encoder_count <= s_encoder_count;
            in_item_reg.limit_negative <= s_limit_negative;
        end
    end

    // one word's worth of control logic
    hpmc_step #(
        .PWM_TOP (PWM_TOP),
        .CW      (CW)
    ) u_step (
        .item     (in_item_reg),
        .cfg      (cfg_reg),
        .st       (st_reg),
        .cmp_cur  (cmp_reg),
        .st_next  (st_next),
        .cmp_next (cmp_next),
        .clear    (clear_next)
    );

    // axis state commits as the word moves into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.phase <= hpmc_pkg::PH_NOT_HOMED;
            st_reg.motion <= 1'b0;
            st_reg.target <= '0;
            st_reg.dir <= 1'b0;
            st_reg.brake <= 1'b0;
            cmp_reg <= TOP_C;
        end else if (advance) begin
            st_reg <= st_next;
            cmp_reg <= cmp_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_dir_reg <= st_next.dir;
            out_cmp_reg <= cmp_next[6:0];
            out_brake_reg <= st_next.brake;
            out_clear_reg <= clear_next;
            out_phase_reg <= st_next.phase;
            out_motion_reg <= st_next.motion;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_drive_negative = out_dir_reg;
    assign m_pwm_compare = out_cmp_reg;
    assign m_brake_release = out_brake_reg;
    assign m_encoder_clear = out_clear_reg;
    assign m_home_status = out_phase_reg;
    assign m_moving = out_motion_reg;

    // encoder clear only comes with homing just completed and motion started
    `HPMC_ASSERT_IMP(a_clear_homed, m_valid && m_encoder_clear, (m_home_status == hpmc_pkg::PH_HOMED) && m_moving, "encoder clear without homing done")
    // the brake is only ever released, so a held brake means a stopped motor
    `HPMC_ASSERT_IMP(a_brake_stopped, !st_reg.brake, cmp_reg == TOP_C, "motor driven with brake applied")
    // once homed and idle the motor must sit at the stopped compare
    `HPMC_ASSERT_IMP(a_idle_stopped, (st_reg.phase == hpmc_pkg::PH_HOMED) && !st_reg.motion, cmp_reg == TOP_C, "homed idle axis not stopped")
    // back-pressure only when the input register is full and cannot drain
    `HPMC_ASSERT_IMP(a_stall_full, !s_ready, in_vld_reg && out_vld_reg && !m_ready, "input stalled without full pipeline")

endmodule

/* tb/tb_homing_position_motor_control_unit.sv */
// self-checking testbench for homing_position_motor_control_unit
// holds its own axis predictor in a small scoreboard class; depends on hpmc_pkg
`timescale 1ns / 1ps

// one input word as driven on the s_ ports; op is kept as raw bits so the
// unused code can be sent too
typedef struct packed {
    logic [1:0]                 op;
    logic [hpmc_pkg::POS_W-1:0] target_position;
    logic [hpmc_pkg::POS_W-1:0] encoder_count;
    logic                       limit_negative;
} axis_cmd_t;

// one result word as seen on the m_ ports
typedef struct packed {
    logic       drive_negative;
    logic [6:0] pwm_compare;
    logic       brake_release;
    logic       encoder_clear;
    logic [1:0] home_status;
    logic       moving;
} motor_pins_t;

localparam logic [1:0] OP_UNUSED = 2'd3;

class homing_axis_scoreboard;
    hpmc_pkg::cfg_t             regs;
    hpmc_pkg::phase_t           phase;
    logic                       motion;
    logic [hpmc_pkg::POS_W-1:0] target;
    logic                       dir;
    logic                       brake;
    logic [6:0]                 cmp;
    motor_pins_t                expected_pins[$];
    int                         mismatches;
    int                         words_noted;
    int                         words_checked;
    int                         homings_done;
    int                         deadband_stops;

    function new();
        regs = '{hpmc_pkg::MOVE_DUTY_RST, hpmc_pkg::HOMING_DUTY_RST,
                 hpmc_pkg::DEADBAND_RST, hpmc_pkg::HOME_TARGET_RST};
        phase = hpmc_pkg::PH_NOT_HOMED;
        motion = 1'b0;
        target = '0;
        dir = 1'b0;
        brake = 1'b0;
        cmp = 7'(hpmc_pkg::PWM_TOP_DEF);
        mismatches = 0;
        words_noted = 0;
        words_checked = 0;
        homings_done = 0;
        deadband_stops = 0;
    endfunction

    function void write_reg(logic [hpmc_pkg::CFG_IDX_W-1:0] idx,
                            logic [hpmc_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            hpmc_pkg::CFG_MOVE_DUTY:   regs.move_duty = data[hpmc_pkg::DUTY_W-1:0];
            hpmc_pkg::CFG_HOMING_DUTY: regs.homing_duty = data[hpmc_pkg::DUTY_W-1:0];
            hpmc_pkg::CFG_DEADBAND:    regs.deadband = data[hpmc_pkg::DB_W-1:0];
            hpmc_pkg::CFG_HOME_TARGET: regs.home_target = data[hpmc_pkg::POS_W-1:0];
            default: ;
        endcase
    endfunction

    // inverted compare, saturating at zero for duties above the top
    function logic [6:0] duty_compare(logic [hpmc_pkg::DUTY_W-1:0] duty);
        if (int'(duty) >= int'(hpmc_pkg::PWM_TOP_DEF))
            return 7'd0;
        return 7'(int'(hpmc_pkg::PWM_TOP_DEF) - int'(duty));
    endfunction

    function void note_word(axis_cmd_t w);
        motor_pins_t p;
        logic clr;
        int err;
        int db;
        clr = 1'b0;
        case (w.op)
            hpmc_pkg::OP_SET_TARGET: begin
                target = w.target_position;
                brake = 1'b1;
                motion = 1'b1;
            end
            hpmc_pkg::OP_HOME: phase = hpmc_pkg::PH_HOMING;
            hpmc_pkg::OP_TICK: begin
                if (phase == hpmc_pkg::PH_HOMING) begin
                    brake = 1'b1;
                    dir = 1'b1;
                    cmp = duty_compare(regs.homing_duty);
                    if (w.limit_negative) begin
                        clr = 1'b1;
                        target = regs.home_target;
                        motion = 1'b1;
                        phase = hpmc_pkg::PH_HOMED;
                        homings_done++;
                    end
                end else if (phase == hpmc_pkg::PH_HOMED) begin
                    if (motion) begin
                        err = int'($signed(target)) - int'($signed(w.encoder_count));
                        db = int'(regs.deadband);
                        if (err > db) begin
                            dir = 1'b0;
                            cmp = duty_compare(regs.move_duty);
                        end else if (err < -db) begin
                            dir = 1'b1;
                            cmp = duty_compare(regs.move_duty);
                        end else begin
                            cmp = 7'(hpmc_pkg::PWM_TOP_DEF);
                            motion = 1'b0;
                            deadband_stops++;
                        end
                    end else begin
                        cmp = 7'(hpmc_pkg::PWM_TOP_DEF);
                    end
                    brake = 1'b1;
                end
            end
            default: ;
        endcase
        p.drive_negative = dir;
        p.pwm_compare = cmp;
        p.brake_release = brake;
        p.encoder_clear = clr;
        p.home_status = phase;
        p.moving = motion;
        expected_pins.push_back(p);
        words_noted++;
    endfunction

    function void check_word(motor_pins_t got);
        motor_pins_t exp_p;
        words_checked++;
        if (expected_pins.size() == 0) begin
            if (mismatches < 10)
                $display({"unexpected result word %0d: dir %0d cmp %0d brake %0d",
                          " clear %0d status %0d moving %0d"},
                         words_checked, got.drive_negative, got.pwm_compare,
                         got.brake_release, got.encoder_clear, got.home_status,
                         got.moving);
            mismatches++;
            return;
        end
        exp_p = expected_pins.pop_front();
        if (got.drive_negative !== exp_p.drive_negative || got.pwm_compare !== exp_p.pwm_compare
                || got.brake_release !== exp_p.brake_release
                || got.encoder_clear !== exp_p.encoder_clear
                || got.home_status !== exp_p.home_status || got.moving !== exp_p.moving) begin
            if (mismatches < 10) begin
                $display("mismatch on result word %0d", words_checked);
                $display("  expected dir %0d cmp %0d brake %0d clear %0d status %0d moving %0d",
                         exp_p.drive_negative, exp_p.pwm_compare, exp_p.brake_release,
                         exp_p.encoder_clear, exp_p.home_status, exp_p.moving);
                $display("  actual   dir %0d cmp %0d brake %0d clear %0d status %0d moving %0d",
                         got.drive_negative, got.pwm_compare, got.brake_release,
                         got.encoder_clear, got.home_status, got.moving);
            end
            mismatches++;
        end
    endfunction
endclass

module tb_homing_position_motor_control_unit;

    // random words per register setting, six settings in all
    localparam int ITEMS_PER_SETTING = 150;
    localparam int NUM_SETTINGS = 6;
    // cycles with no handshake on either side before giving up
    localparam int WATCHDOG_LIMIT = 500;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                            cfg_we = 1'b0;
    logic [hpmc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [hpmc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic [1:0]                        s_operation = '0;
    logic signed [hpmc_pkg::POS_W-1:0] s_target_position = '0;
    logic [hpmc_pkg::POS_W-1:0]        s_encoder_count = '0;
    logic                              s_limit_negative = 1'b0;

    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_drive_negative;
    logic [6:0] m_pwm_compare;
    logic       m_brake_release;
    logic       m_encoder_clear;
    logic [1:0] m_home_status;
    logic       m_moving;

    // when set, both sides run back to back with no idle cycles
    logic steady = 1'b0;

    homing_axis_scoreboard sb;

    homing_position_motor_control_unit DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_target_position (s_target_position),
        .s_encoder_count   (s_encoder_count),
        .s_limit_negative  (s_limit_negative),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_drive_negative  (m_drive_negative),
        .m_pwm_compare     (m_pwm_compare),
        .m_brake_release   (m_brake_release),
        .m_encoder_clear   (m_encoder_clear),
        .m_home_status     (m_home_status),
        .m_moving          (m_moving)
    );

    // 50 MHz clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // present one word and hold it until accepted; afterwards draw the gap
    // before the next word, leaving valid high when the gap is zero
    task automatic send_word(input logic [1:0] op, input logic [hpmc_pkg::POS_W-1:0] tpos,
                             input logic [hpmc_pkg::POS_W-1:0] enc, input logic lim);
        axis_cmd_t w;
        int gap;
        w = '{op, tpos, enc, lim};
        s_valid <= 1'b1;
        s_operation <= op;
        s_target_position <= tpos;
        s_encoder_count <= enc;
        s_limit_negative <= lim;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(w);
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // drop valid and let every outstanding result drain before touching config
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.expected_pins.size() != 0) @(posedge aclk);
        // pipeline is two registers deep; wait on after the queue empties
        repeat (4) @(posedge aclk);
    endtask

    // one register write per edge; for the narrower fields the upper data bits carry
    // junk that the block must mask away
    task automatic write_reg(input logic [hpmc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hpmc_pkg::CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    // one stretch of random stimulus; n counts the words that do something
    task automatic run_episode(inout int n);
        int kind;
        int k;
        int cnt;
        int err;
        int db;
        logic [1:0] op;
        logic [hpmc_pkg::POS_W-1:0] tgt;
        steady <= ($urandom_range(0, 5) == 0);
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            // plain noise, unused code now and then
            cnt = $urandom_range(1, 4);
            for (k = 0; k < cnt; k++) begin
                op = ($urandom_range(0, 15) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
                send_word(op, 16'($urandom), 16'($urandom), 1'($urandom));
                if (op != OP_UNUSED)
                    n++;
            end
        end else if (kind < 4) begin
            // homing run: a few ticks seeking the switch, mostly closing it
            send_word(hpmc_pkg::OP_HOME, 16'($urandom), 16'($urandom), 1'($urandom));
            n++;
            cnt = $urandom_range(0, 4);
            for (k = 0; k < cnt; k++) begin
                send_word(hpmc_pkg::OP_TICK, 16'($urandom), 16'($urandom), 1'b0);
                n++;
            end
            if ($urandom_range(0, 3) != 0) begin
                send_word(hpmc_pkg::OP_TICK, 16'($urandom), 16'($urandom), 1'b1);
                n++;
            end
        end else begin
            // move: optional new target, then ticks with the encoder placed
            // around the deadband edges
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 7))
                    0: tgt = 16'h8000;
                    1: tgt = 16'h7FFF;
                    2: tgt = 16'h0000;
                    3: tgt = 16'hFFFF;
                    default: tgt = 16'($urandom);
                endcase
                send_word(hpmc_pkg::OP_SET_TARGET, tgt, 16'($urandom), 1'($urandom));
                n++;
            end
            cnt = $urandom_range(1, 8);
            for (k = 0; k < cnt; k++) begin
                db = int'(sb.regs.deadband);
                case ($urandom_range(0, 6))
                    0: err = db;
                    1: err = db + 1;
                    2: err = -db;
                    3: err = -db - 1;
                    4: err = int'($urandom_range(0, 2 * db)) - db;
                    5: err = int'($signed(16'($urandom)));
                    default: err = int'($urandom_range(0, 40)) - 20;
                endcase
                send_word(hpmc_pkg::OP_TICK, 16'($urandom),
                          16'(int'($signed(sb.target)) - err), 1'($urandom));
                n++;
            end
        end
    endtask

    // result side: random stall per word, then check whatever comes out
    initial begin : result_side
        int stall;
        motor_pins_t got;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 5);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            got.drive_negative = m_drive_negative;
            got.pwm_compare = m_pwm_compare;
            got.brake_release = m_brake_release;
            got.encoder_clear = m_encoder_clear;
            got.home_status = m_home_status;
            got.moving = m_moving;
            sb.check_word(got);
        end
    end

    // watchdog: any handshake restarts the count
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout after %0d quiet cycles, %0d results still due",
                 quiet, sb.expected_pins.size());
        $display("tb_homing_position_motor_control_unit: FAIL");
        $finish;
    end

    initial begin : stimulus
        int ph;
        int n;
        hpmc_pkg::cfg_t setting;
        sb = new();

        // reset held low from the start, released once
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (ph = 0; ph < NUM_SETTINGS; ph++) begin
            drain_results();
            case (ph)
                // reset values, written anyway
                0: setting = '{hpmc_pkg::MOVE_DUTY_RST, hpmc_pkg::HOMING_DUTY_RST,
                               hpmc_pkg::DEADBAND_RST, hpmc_pkg::HOME_TARGET_RST};
                // all low, no deadband at all
                1: setting = '{7'd0, 7'd0, 15'd0, 16'h8000};
                // full drive, widest deadband
                2: setting = '{7'd100, 7'd100, 15'h7FFF, 16'h7FFF};
                // duties past the top saturate the compare
                3: setting = '{7'd127, 7'd101, 15'd1, 16'h0000};
                4: setting = '{7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                               15'($urandom_range(0, 300)), 16'($urandom)};
                default: setting = '{7'd99, 7'd1, 15'd3, 16'hFE0C};
            endcase
            write_reg(hpmc_pkg::CFG_MOVE_DUTY, {9'($urandom), setting.move_duty});
            write_reg(hpmc_pkg::CFG_HOMING_DUTY, {9'($urandom), setting.homing_duty});
            write_reg(hpmc_pkg::CFG_DEADBAND, {1'($urandom), setting.deadband});
            write_reg(hpmc_pkg::CFG_HOME_TARGET, setting.home_target);
            cfg_we <= 1'b0;

            if (ph == 0) begin
                // not homed: ticks change nothing, even with the switch closed
                send_word(hpmc_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0);
                send_word(hpmc_pkg::OP_TICK, 16'hFFFF, 16'hFFFF, 1'b1);
                send_word(OP_UNUSED, 16'h1234, 16'h4321, 1'b1);
                // target taken while not homed: brake released, motion flagged,
                // nothing driven until homed
                send_word(hpmc_pkg::OP_SET_TARGET, 16'h7FFF, 16'h0000, 1'b0);
                send_word(hpmc_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0);
                // homing: seek negative, then close the switch
                send_word(hpmc_pkg::OP_HOME, 16'h0000, 16'h0000, 1'b0);
                send_word(hpmc_pkg::OP_TICK, 16'h0000, 16'hFFFF, 1'b0);
                send_word(hpmc_pkg::OP_TICK, 16'h0000, 16'h8000, 1'b0);
                send_word(hpmc_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b1);
                // just outside, then on the deadband edge around home target
                send_word(hpmc_pkg::OP_TICK, 16'h0000, 16'd415, 1'b0);
                send_word(hpmc_pkg::OP_TICK, 16'h0000, 16'd416, 1'b0);
                // idle homed tick
                send_word(hpmc_pkg::OP_TICK, 16'h0000, 16'd0, 1'b1);
                // most negative target against most positive count
                send_word(hpmc_pkg::OP_SET_TARGET, 16'h8000, 16'h0000, 1'b0);
                send_word(hpmc_pkg::OP_TICK, 16'h0000, 16'h7FFF, 1'b0);
                send_word(hpmc_pkg::OP_TICK, 16'h0000, 16'h800A, 1'b0);
                send_word(hpmc_pkg::OP_SET_TARGET, 16'h7FFF, 16'hFFFF, 1'b1);
                send_word(hpmc_pkg::OP_TICK, 16'h0000, 16'h8000, 1'b0);
                send_word(hpmc_pkg::OP_TICK, 16'h0000, 16'h7FF4, 1'b0);
                send_word(OP_UNUSED, 16'hFFFF, 16'hFFFF, 1'b0);
                // homing again from homed
                send_word(hpmc_pkg::OP_HOME, 16'hFFFF, 16'hFFFF, 1'b1);
                send_word(hpmc_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b1);
                send_word(hpmc_pkg::OP_TICK, 16'h0000, 16'd437, 1'b0);
                send_word(hpmc_pkg::OP_TICK, 16'h0000, 16'd436, 1'b0);
                send_word(hpmc_pkg::OP_SET_TARGET, 16'hFFFF, 16'h0000, 1'b0);
                send_word(hpmc_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0);
            end

            n = 0;
            while (n < ITEMS_PER_SETTING)
                run_episode(n);
        end

        // let the tail drain, then wait on for anything stray
        drain_results();
        repeat (8) @(posedge aclk);

        $display("covered %0d words over %0d register settings, %0d results checked",
                 sb.words_noted, NUM_SETTINGS, sb.words_checked);
        $display("homing completed %0d times, %0d stops inside the deadband, %0d mismatches",
                 sb.homings_done, sb.deadband_stops, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_pins.size() == 0)
            $display("tb_homing_position_motor_control_unit: PASS");
        else
            $display("tb_homing_position_motor_control_unit: FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/hpmc_pkg.sv
rtl/core/hpmc_step.sv
rtl/core/homing_position_motor_control_unit.sv
tb/tb_homing_position_motor_control_unit.sv
